// ===== rtl/core/tccs_pkg.sv =====
// Shared types and constants for the text console cursor/scroll engine.
// No dependencies; used by the core, the port checker and the testbench.
`timescale 1ns / 1ps

package tccs_pkg;

    // screen geometry
    localparam int MAX_COLS   = 80;
    localparam int MAX_ROWS   = 25;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // field widths fixed by the interface
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int CELL_W    = CHAR_W + COLOR_W;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 24;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CH_BLANK};

    // result item, row in the lowest bits
    typedef struct packed {
        logic [COLOR_W-1:0] cell_color;
        logic [CHAR_W-1:0]  cell_char;
        logic               scrolled;
        logic [ADDR_W-1:0]  cursor_linear;
        logic [COL_W-1:0]   cursor_col;
        logic [ROW_W-1:0]   cursor_row;
    } t_result;

endpackage

// ===== rtl/core/tccs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; holds the screen cells of the console core.
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/text_console_cursor_scroll.sv =====
// Top level of the text console engine: cursor logic, scroll/clear sequencer.
// Depends on tccs_pkg and the screen RAM tccs_ram.
`timescale 1ns / 1ps

// channel   direction  handshake                      contents
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser opcode, tdata char/cell index
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata cursor, scrolled, read cell
// cfg       in         i_cfg_valid / o_cfg_ready      register index and write data
//
// put without scroll, carriage return, unused opcode: a new request each cycle while no result is stalled
// read cell: the registered read port of the screen RAM adds the S_READ state
// scroll: one cell copied per cycle through the RAM, then the bottom row blanked
// clear: one cell blanked per cycle
// after reset a pass writes every cell blank; no request is taken meanwhile
// a stalled result holds the next request off; configuration is always taken

module text_console_cursor_scroll (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request: tdata [7:0] char_code, [18:8] cell_index, zero above
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tccs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser [1:0] opcode
    input  logic [tccs_pkg::OP_W-1:0]           s_axis_tuser,
    // result: tdata [4:0] cursor_row, [11:5] cursor_col, [22:12] cursor_linear,
    // [23] scrolled, [31:24] cell_char, [39:32] cell_color
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [$bits(tccs_pkg::t_result)-1:0] m_axis_tdata,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tccs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tccs_pkg::COLOR_W-1:0]        i_cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_COPY,
        S_BLANK
    } t_state;

    localparam int AW = tccs_pkg::ADDR_W;
    localparam int RW = tccs_pkg::ROW_W;
    localparam int CW = tccs_pkg::COL_W;

    // row * cols + col on the screen
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                 input logic [CW-1:0] col,
                                                 input logic [CW-1:0] cols);
        logic [AW+1:0] sum;
        sum = (AW+2)'(row) * (AW+2)'(cols) + (AW+2)'(col);
        return sum[AW-1:0];
    endfunction

    t_state                        r_state;
    logic [AW-1:0]                 r_ptr;
    logic [AW-1:0]                 r_dst;
    logic                          r_pend;
    logic                          r_rd_ok;
    logic [RW-1:0]                 r_row;
    logic [CW-1:0]                 r_col;
    logic [tccs_pkg::COLOR_W-1:0]  r_color;
    logic [CW-1:0]                 r_cols;
    logic [RW-1:0]                 r_rows;
    tccs_pkg::t_result             r_res;
    tccs_pkg::t_result             r_mdata;
    logic                          r_mv;

    logic                          w_acc;
    logic [tccs_pkg::OP_W-1:0]     w_op;
    logic [tccs_pkg::CHAR_W-1:0]   w_ch;
    logic [AW-1:0]                 w_ci;
    logic [RW-1:0]                 w_row_s;
    logic [CW-1:0]                 w_col_s;
    logic                          w_nr_last;
    logic [RW-1:0]                 w_nr_row;
    logic [CW:0]                   w_tab;
    logic [CW:0]                   w_col_inc;
    logic [RW-1:0]                 n_row;
    logic [CW-1:0]                 n_col;
    logic                          w_scroll;
    logic                          w_put_we;
    logic [RW-1:0]                 w_wrow;
    logic [CW-1:0]                 w_wcol;
    logic [tccs_pkg::CHAR_W-1:0]   w_wchar;
    logic [AW-1:0]                 w_lim;
    logic [AW-1:0]                 w_lin;
    tccs_pkg::t_result             w_res;
    tccs_pkg::t_result             w_rd_res;
    logic                          w_mv_set;

    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [tccs_pkg::CELL_W-1:0]   w_wdata;
    logic [AW-1:0]                 w_raddr;
    logic [tccs_pkg::CELL_W-1:0]   w_rdata;

    // handshakes
    assign s_axis_tready = (r_state == S_IDLE) && (!r_mv || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = r_mdata;

    assign w_op = s_axis_tuser;
    assign w_ch = s_axis_tdata[tccs_pkg::CHAR_W-1:0];
    assign w_ci = s_axis_tdata[tccs_pkg::CHAR_W +: AW];

    // cursor saturated into the active area
    assign w_row_s = (r_row >= r_rows) ? RW'(r_rows - 1'b1) : r_row;
    assign w_col_s = (r_col >= r_cols) ? CW'(r_cols - 1'b1) : r_col;

    // move to the next row, scroll from the bottom row
    assign w_nr_last = ({1'b0, w_row_s} + 1'b1) >= {1'b0, r_rows};
    assign w_nr_row  = w_nr_last ? RW'(r_rows - 1'b1) : RW'(w_row_s + 1'b1);
    assign w_tab     = ({1'b0, w_col_s} + (CW+1)'(4)) & ~(CW+1)'(3);
    assign w_col_inc = {1'b0, w_col_s} + 1'b1;

    // cursor update and cell write of one request
    always_comb begin
        n_row    = w_row_s;
        n_col    = w_col_s;
        w_scroll = 1'b0;
        w_put_we = 1'b0;
        w_wrow   = w_row_s;
        w_wcol   = w_col_s;
        w_wchar  = w_ch;
        unique case (w_op)
            tccs_pkg::OP_PUT: begin
                priority if (w_ch == tccs_pkg::CH_LF) begin
                    n_col    = '0;
                    n_row    = w_nr_row;
                    w_scroll = w_nr_last;
                end else if (w_ch == tccs_pkg::CH_CR) begin
                    n_col = '0;
                end else if (w_ch == tccs_pkg::CH_TAB) begin
                    if (w_tab >= {1'b0, r_cols}) begin
                        n_col    = '0;
                        n_row    = w_nr_row;
                        w_scroll = w_nr_last;
                    end else begin
                        n_col = w_tab[CW-1:0];
                    end
                end else if (w_ch == tccs_pkg::CH_BS) begin
                    w_wchar = tccs_pkg::CH_BLANK;
                    if (w_col_s != '0) begin
                        n_col    = CW'(w_col_s - 1'b1);
                        w_wcol   = CW'(w_col_s - 1'b1);
                        w_put_we = 1'b1;
                    end else if (w_row_s != '0) begin
                        n_row    = RW'(w_row_s - 1'b1);
                        n_col    = CW'(r_cols - 1'b1);
                        w_wrow   = RW'(w_row_s - 1'b1);
                        w_wcol   = CW'(r_cols - 1'b1);
                        w_put_we = 1'b1;
                    end
                end else begin
                    w_put_we = 1'b1;
                    if (w_col_inc >= {1'b0, r_cols}) begin
                        n_col    = '0;
                        n_row    = w_nr_row;
                        w_scroll = w_nr_last;
                    end else begin
                        n_col = w_col_inc[CW-1:0];
                    end
                end
            end
            tccs_pkg::OP_CLEAR: begin
                n_row = '0;
                n_col = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_lim = cell_addr(r_rows, '0, r_cols);
    assign w_lin = cell_addr(n_row, n_col, r_cols);

    // cursor part of the result
    always_comb begin
        w_res               = '0;
        w_res.cursor_row    = n_row;
        w_res.cursor_col    = n_col;
        w_res.cursor_linear = w_lin;
        w_res.scrolled      = w_scroll;
    end

    // read result with the cell data merged in when the index is in the store
    always_comb begin
        w_rd_res = r_res;
        if (r_rd_ok) begin
            w_rd_res.cell_char  = w_rdata[tccs_pkg::CHAR_W-1:0];
            w_rd_res.cell_color = w_rdata[tccs_pkg::CELL_W-1:tccs_pkg::CHAR_W];
        end
    end

    // a result becomes ready this cycle
    assign w_mv_set = ((r_state == S_IDLE) && w_acc && (w_op != tccs_pkg::OP_CLEAR)
                       && (w_op != tccs_pkg::OP_READ) && !w_scroll)
                   || (r_state == S_READ)
                   || ((r_state == S_BLANK) && (r_ptr == AW'(w_lim - 1'b1)));

    // screen RAM port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = w_ci;
        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = tccs_pkg::RESET_CELL;
            end
            S_IDLE: begin
                w_we    = w_acc && w_put_we;
                w_waddr = cell_addr(w_wrow, w_wcol, r_cols);
                w_wdata = {r_color, w_wchar};
            end
            S_COPY: begin
                w_raddr = r_ptr;
                w_we    = r_pend;
                w_waddr = r_dst;
                w_wdata = w_rdata;
            end
            S_BLANK: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = {r_color, tccs_pkg::CH_BLANK};
            end
            default: begin
            end
        endcase
    end

    tccs_ram #(
        .WIDTH(tccs_pkg::CELL_W),
        .DEPTH(tccs_pkg::CELL_COUNT)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // sequencer, cursor, registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_mv    <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_color <= tccs_pkg::RESET_COLOR;
            r_cols  <= CW'(tccs_pkg::MAX_COLS);
            r_rows  <= RW'(tccs_pkg::MAX_ROWS);
        end else begin
            // register writes, sizes kept within 1 and the maximum
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tccs_pkg::CFG_COLOR: r_color <= i_cfg_data;
                    tccs_pkg::CFG_COLS: begin
                        if (i_cfg_data[CW-1:0] == '0) begin
                            r_cols <= CW'(1);
                        end else if (i_cfg_data[CW-1:0] > CW'(tccs_pkg::MAX_COLS)) begin
                            r_cols <= CW'(tccs_pkg::MAX_COLS);
                        end else begin
                            r_cols <= i_cfg_data[CW-1:0];
                        end
                    end
                    tccs_pkg::CFG_ROWS: begin
                        if (i_cfg_data[RW-1:0] == '0) begin
                            r_rows <= RW'(1);
                        end else if (i_cfg_data[RW-1:0] > RW'(tccs_pkg::MAX_ROWS)) begin
                            r_rows <= RW'(tccs_pkg::MAX_ROWS);
                        end else begin
                            r_rows <= i_cfg_data[RW-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // result valid: set when a result is ready, held until taken
            r_mv <= w_mv_set || (r_mv && !m_axis_tready);

            unique case (r_state)
                // blank every cell after reset
                S_INIT: begin
                    r_ptr <= AW'(r_ptr + 1'b1);
                    if (r_ptr == AW'(tccs_pkg::CELL_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        r_row   <= n_row;
                        r_col   <= n_col;
                        r_res   <= w_res;
                        r_rd_ok <= (w_ci < AW'(tccs_pkg::CELL_COUNT));
                        if (w_op == tccs_pkg::OP_CLEAR) begin
                            r_ptr   <= '0;
                            r_state <= S_BLANK;
                        end else if (w_op == tccs_pkg::OP_READ) begin
                            r_state <= S_READ;
                        end else if (w_scroll) begin
                            r_ptr   <= AW'(r_cols);
                            r_pend  <= 1'b0;
                            r_state <= S_COPY;
                        end else begin
                            r_mdata <= w_res;
                        end
                    end
                end
                // cell data arrives in the cycle after the read
                S_READ: begin
                    r_mdata <= w_rd_res;
                    r_state <= S_IDLE;
                end
                // move every row up: read a cell, write it one row higher next cycle
                S_COPY: begin
                    r_pend <= (r_ptr < w_lim);
                    if (r_ptr < w_lim) begin
                        r_dst <= AW'(r_ptr - AW'(r_cols));
                        r_ptr <= AW'(r_ptr + 1'b1);
                    end else begin
                        r_ptr   <= AW'(w_lim - AW'(r_cols));
                        r_state <= S_BLANK;
                    end
                end
                // blank up to the end of the active area
                S_BLANK: begin
                    r_ptr <= AW'(r_ptr + 1'b1);
                    if (r_ptr == AW'(w_lim - 1'b1)) begin
                        r_mdata <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/tccs_checker.sv =====
// Port-level checker for the text console engine, bound to the top level.
// Depends on tccs_pkg; sees only the ports of text_console_cursor_scroll.
`timescale 1ns / 1ps

module tccs_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [$bits(tccs_pkg::t_result)-1:0] m_axis_tdata
);

    tccs_pkg::t_result w_res;

    assign w_res = m_axis_tdata;

    // the blanking pass after reset holds requests off
    a_init_busy: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("request taken right after reset");

    // a waiting result blocks the next request
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tready))
        else $error("request taken while a result is stalled");

    // reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_res.cursor_row < tccs_pkg::ROW_W'(tccs_pkg::MAX_ROWS))
                       && (w_res.cursor_col < tccs_pkg::COL_W'(tccs_pkg::MAX_COLS)))
        else $error("cursor outside the screen");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the text console engine: directed and random requests,
// an in-bench screen shadow predicts every result. Depends on tccs_pkg and the top level.
`timescale 1ns / 1ps

module testbench;
    import tccs_pkg::*;

    localparam logic [OP_W-1:0]      OP_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_PHASES   = 13;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRESSURE_AT     = 250;
    localparam int PRESSURE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int MAX_REPORTS     = 40;

    // shadow of the screen store, cursor and size registers
    class console_shadow;
        logic [CELL_W-1:0]  cells [CELL_COUNT];
        int unsigned        row;
        int unsigned        col;
        logic [COLOR_W-1:0] color;
        logic [COL_W-1:0]   cols_reg;
        logic [ROW_W-1:0]   rows_reg;
        t_result            expected_cursor_q [$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        n_requests;
        int unsigned        n_scrolls;
        int unsigned        n_clears;
        int unsigned        n_reads;

        function new();
            foreach (cells[i]) cells[i] = RESET_CELL;
            row        = 0;
            col        = 0;
            color      = RESET_COLOR;
            cols_reg   = COL_W'(MAX_COLS);
            rows_reg   = ROW_W'(MAX_ROWS);
            mismatches = 0;
            checked    = 0;
            n_requests = 0;
            n_scrolls  = 0;
            n_clears   = 0;
            n_reads    = 0;
        endfunction

        // zero acts as one, oversize acts as the maximum
        function int unsigned active_cols();
            int unsigned c;
            c = cols_reg;
            if (c < 1) c = 1;
            if (c > MAX_COLS) c = MAX_COLS;
            return c;
        endfunction

        function int unsigned active_rows();
            int unsigned r;
            r = rows_reg;
            if (r < 1) r = 1;
            if (r > MAX_ROWS) r = MAX_ROWS;
            return r;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
            case (idx)
                CFG_COLOR: color = data;
                CFG_COLS:  cols_reg = data[COL_W-1:0];
                CFG_ROWS:  rows_reg = data[ROW_W-1:0];
                default: ;
            endcase
        endfunction

        // start of next row, scroll up at the bottom; returns 1 on scroll
        function bit next_line();
            int unsigned c;
            int unsigned r;
            c   = active_cols();
            r   = active_rows();
            col = 0;
            if (row + 1 < r) begin
                row++;
                return 1'b0;
            end
            row = r - 1;
            for (int unsigned y = 1; y < r; y++)
                for (int unsigned x = 0; x < c; x++)
                    cells[(y - 1) * c + x] = cells[y * c + x];
            for (int unsigned x = 0; x < c; x++)
                cells[(r - 1) * c + x] = {color, CH_BLANK};
            return 1'b1;
        endfunction

        // predict the result of one accepted request
        function void take_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                   logic [ADDR_W-1:0] ci);
            int unsigned c;
            int unsigned r;
            bit          did_scroll;
            t_result     want;
            c          = active_cols();
            r          = active_rows();
            did_scroll = 1'b0;
            want       = '0;
            n_requests++;
            // cursor kept inside a shrunk area
            if (row >= r) row = r - 1;
            if (col >= c) col = c - 1;
            case (op)
                OP_PUT: begin
                    if (ch == CH_LF) begin
                        did_scroll = next_line();
                    end else if (ch == CH_CR) begin
                        col = 0;
                    end else if (ch == CH_TAB) begin
                        col = (col + 4) & ~32'd3;
                        if (col >= c) did_scroll = next_line();
                    end else if (ch == CH_BS) begin
                        // erase backwards, wrapping to the end of the previous row
                        if (col > 0) begin
                            col--;
                            cells[row * c + col] = {color, CH_BLANK};
                        end else if (row > 0) begin
                            row--;
                            col = c - 1;
                            cells[row * c + col] = {color, CH_BLANK};
                        end
                    end else begin
                        cells[row * c + col] = {color, ch};
                        col++;
                        if (col >= c) did_scroll = next_line();
                    end
                end
                OP_CLEAR: begin
                    n_clears++;
                    for (int unsigned y = 0; y < r; y++)
                        for (int unsigned x = 0; x < c; x++)
                            cells[y * c + x] = {color, CH_BLANK};
                    row = 0;
                    col = 0;
                end
                OP_READ: begin
                    n_reads++;
                    if (ci < CELL_COUNT) begin
                        want.cell_char  = cells[ci][CHAR_W-1:0];
                        want.cell_color = cells[ci][CELL_W-1:CHAR_W];
                    end
                end
                default: ;
            endcase
            if (did_scroll) n_scrolls++;
            want.cursor_row    = ROW_W'(row);
            want.cursor_col    = COL_W'(col);
            want.cursor_linear = ADDR_W'(row * c + col);
            want.scrolled      = did_scroll;
            expected_cursor_q.push_back(want);
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("[%0t] ERROR %s", $time, msg);
        endtask

        task compare(string field, logic [15:0] got_v, logic [15:0] want_v);
            if (got_v !== want_v)
                report($sformatf("result %0d %s: got %0h expected %0h",
                                 checked, field, got_v, want_v));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_cursor_q.size() == 0) begin
                report($sformatf("result %h with no request waiting", got));
                return;
            end
            want = expected_cursor_q.pop_front();
            checked++;
            compare("cursor_row", got.cursor_row, want.cursor_row);
            compare("cursor_col", got.cursor_col, want.cursor_col);
            compare("cursor_linear", got.cursor_linear, want.cursor_linear);
            compare("scrolled", got.scrolled, want.scrolled);
            compare("cell_char", got.cell_char, want.cell_char);
            compare("cell_color", got.cell_color, want.cell_color);
        endtask
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_W-1:0]      s_axis_tdata  = '0;
    logic [OP_W-1:0]           s_axis_tuser  = OP_PUT;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [$bits(t_result)-1:0] m_axis_tdata;
    logic                      i_cfg_valid   = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index   = CFG_COLOR;
    logic [COLOR_W-1:0]        i_cfg_data    = '0;

    console_shadow shadow = new();
    bit            steady_flow = 1'b0;
    int unsigned   idle_cycles = 0;
    int unsigned   n_settings  = 0;

    text_console_cursor_scroll DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // idle stretch: mostly short, now and then long
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // offer one request, wait for the handshake, then maybe idle
    task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [ADDR_W-1:0] ci, input bit last_one);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - ADDR_W - CHAR_W){1'b0}}, ci, ch};
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.take_request(op, ch, ci);
        gap = (steady_flow || $urandom_range(0, 99) >= 40) ? 0 : idle_span();
        if (gap > 0 || last_one) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.set_register(idx, data);
    endtask

    task automatic set_screen(input logic [COLOR_W-1:0] color_v,
                              input logic [COLOR_W-1:0] cols_data,
                              input logic [COLOR_W-1:0] rows_data);
        write_reg(CFG_COLOR, color_v);
        write_reg(CFG_COLS, cols_data);
        write_reg(CFG_ROWS, rows_data);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic wait_drained();
        while (shadow.expected_cursor_q.size() != 0) @(posedge i_clk);
    endtask

    // result side: random ready, one long hold-off to back the block up
    initial begin
        int  hold;
        bit  pressure_done;
        logic ready_next;
        hold          = 0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                shadow.check_result(t_result'(m_axis_tdata));
            if (!pressure_done && shadow.checked == PRESSURE_AT) begin
                hold          = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end else if (hold == 0 && !steady_flow && $urandom_range(0, 99) < 25) begin
                hold = idle_span();
            end
            if (hold > 0) begin
                ready_next = 1'b0;
                hold--;
            end else begin
                ready_next = 1'b1;
            end
            m_axis_tready <= ready_next;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [CHAR_W-1:0]  ch;
        logic [ADDR_W-1:0]  ci;
        logic [COL_W-1:0]   cols_v;
        logic [ROW_W-1:0]   rows_v;
        logic [COLOR_W-1:0] color_v;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: blank store, edges of the store, every put kind
        send_request(OP_READ, 8'h00, '0, 1'b0);
        send_request(OP_READ, 8'hFF, ADDR_W'(CELL_COUNT - 1), 1'b0);
        send_request(OP_READ, 8'h00, ADDR_W'(CELL_COUNT), 1'b0);
        send_request(OP_READ, 8'h00, '1, 1'b0);
        send_request(OP_PUT, 8'h41, '0, 1'b0);
        send_request(OP_PUT, 8'hFF, '1, 1'b0);
        send_request(OP_PUT, 8'h00, '0, 1'b0);
        send_request(OP_PUT, CH_BS, '0, 1'b0);
        send_request(OP_PUT, CH_TAB, '0, 1'b0);
        send_request(OP_PUT, CH_CR, '0, 1'b0);
        send_request(OP_PUT, CH_LF, '0, 1'b0);
        // backspace at column zero wraps to the end of row zero
        send_request(OP_PUT, CH_BS, '0, 1'b0);
        send_request(OP_NONE, 8'h5A, '1, 1'b0);
        send_request(OP_READ, 8'h00, ADDR_W'(MAX_COLS - 1), 1'b0);
        send_request(OP_CLEAR, 8'h00, '0, 1'b0);
        // backspace at home does nothing
        send_request(OP_PUT, CH_BS, '0, 1'b1);

        // tiny 3x2 screen, upper data bits set, plus a write to no register
        wait_drained();
        write_reg(CFG_UNUSED, 8'h5A);
        set_screen(8'hA5, 8'h83, 8'hE2);
        send_request(OP_PUT, 8'h78, '0, 1'b0);
        send_request(OP_PUT, 8'h79, '0, 1'b0);
        send_request(OP_PUT, 8'h7A, '0, 1'b0);
        send_request(OP_PUT, CH_TAB, '0, 1'b0);
        send_request(OP_PUT, CH_LF, '0, 1'b0);
        send_request(OP_READ, 8'h00, '0, 1'b0);
        send_request(OP_READ, 8'h00, 11'd3, 1'b0);
        send_request(OP_PUT, CH_BS, '0, 1'b1);

        // random phases, extremes of the sizes first
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            color_v = 8'($urandom);
            cols_v  = 7'($urandom_range(1, 12));
            rows_v  = 5'($urandom_range(1, 6));
            case (phase)
                0: begin cols_v = 7'd1;   rows_v = 5'd1;  color_v = 8'h00; end
                1: begin cols_v = 7'd0;   rows_v = 5'd0;  color_v = 8'hFF; end
                2: begin cols_v = 7'd80;  rows_v = 5'd25; end
                3: begin cols_v = 7'd127; rows_v = 5'd31; end
                4: begin cols_v = 7'd4;   rows_v = 5'd3;  end
                5: begin cols_v = 7'd79;  rows_v = 5'd2;  end
                6: begin cols_v = 7'd2;   rows_v = 5'd24; end
                default: ;
            endcase
            set_screen(color_v, {1'($urandom), cols_v}, {3'($urandom), rows_v});
            steady_flow = (phase % 4 == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                op   = OP_PUT;
                ch   = 8'($urandom);
                ci   = 11'($urandom);
                if (pick < 58) ;
                else if (pick < 68) ch = CH_LF;
                else if (pick < 72) ch = CH_CR;
                else if (pick < 78) ch = CH_TAB;
                else if (pick < 87) ch = CH_BS;
                else if (pick < 89) op = OP_CLEAR;
                else if (pick < 98) begin
                    op = OP_READ;
                    // mostly inside the active area, else anywhere
                    if ($urandom_range(0, 9) < 7)
                        ci = 11'($urandom_range(0,
                                 shadow.active_cols() * shadow.active_rows() - 1));
                end else begin
                    op = OP_NONE;
                end
                send_request(op, ch, ci, n == ITEMS_PER_PHASE - 1);
            end
        end
        steady_flow = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.expected_cursor_q.size() != 0)
            shadow.report($sformatf("%0d results never arrived",
                                    shadow.expected_cursor_q.size()));
        $display("Ran %0d requests: %0d scrolls, %0d clears, %0d cell reads, %0d checked",
                 shadow.n_requests, shadow.n_scrolls, shadow.n_clears, shadow.n_reads,
                 shadow.checked);
        $display("Screen settings used: %0d, from a single cell up to full size", n_settings);
        if (shadow.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== text_console_cursor_scroll.f =====
rtl/core/tccs_pkg.sv
rtl/core/tccs_ram.sv
rtl/core/text_console_cursor_scroll.sv
rtl/core/tccs_checker.sv
tb/sv/testbench.sv
